// ===== sv/serial_packet_deframer_defines.svh =====
// assertion macros used by the deframer core (spd_core)
`ifndef SERIAL_PACKET_DEFRAMER_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_DEFINES_SVH

// checked at every rising edge outside of reset
`define SPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define SPD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/spd_pkg.sv =====
package spd_pkg;

   localparam int BYTE_W  = 8;
   localparam int SUM_W   = 16;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hFA;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'hFB;
   localparam logic [BYTE_W-1:0] MIN_LENGTH        = 8'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BADLEN   = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT0   = 3'd0,
      PH_HUNT1   = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CKHI    = 3'd4,
      PH_CKLO    = 3'd5
   } phase_type;

   // registered input byte handed to the deframer core
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } in_item_type;

endpackage

// ===== sv/spd_in_stage.sv =====
module spd_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [spd_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                         core_take,
   output spd_pkg::in_item_type         item
);
   import spd_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // register is free when empty or being drained by the core this cycle
   assign req_stall = valid_ff & ~core_take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            data_in = req_in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

// ===== sv/spd_core.sv =====
`include "serial_packet_deframer_defines.svh"

module spd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  spd_pkg::in_item_type          item,
   output logic                          core_take,
   input  logic                          csr_write,
   input  logic [spd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spd_pkg::BYTE_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_item_kind,
   output logic [spd_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [spd_pkg::STAT_W-1:0]    rsp_end_status,
   output logic [spd_pkg::BYTE_W-1:0]    rsp_payload_count,
   output logic [spd_pkg::SUM_W-1:0]     rsp_computed_sum
);
   import spd_pkg::*;

   logic [BYTE_W-1:0] first_sync_ff;
   logic [BYTE_W-1:0] second_sync_ff;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [SUM_W-1:0]  sum_acc_ff, sum_acc_in;
   logic [BYTE_W-1:0] held_high_ff, held_high_in;
   logic              held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0] rx_sum_high_ff, rx_sum_high_in;
   logic [BYTE_W-1:0] payload_len_ff, payload_len_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [BYTE_W-1:0] out_count_ff, out_count_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;

   logic              fire;
   logic              emit;
   logic [BYTE_W-1:0] b;
   logic [SUM_W-1:0]  calc;
   logic [SUM_W-1:0]  rx_sum;

   // the result register takes a new item when empty or being drained
   assign core_take = ~out_valid_ff | ~rsp_stall;
   assign fire      = item.valid & core_take;
   assign b         = item.data;

   assign calc   = held_valid_ff ? (sum_acc_ff ^ {{(SUM_W-BYTE_W){1'b0}}, held_high_ff})
                                 : sum_acc_ff;
   assign rx_sum = {rx_sum_high_ff, b};

   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      sum_acc_in     = sum_acc_ff;
      held_high_in   = held_high_ff;
      held_valid_in  = held_valid_ff;
      rx_sum_high_in = rx_sum_high_ff;
      payload_len_in = payload_len_ff;
      emit           = 1'b0;
      out_kind_in    = out_kind_ff;
      out_byte_in    = out_byte_ff;
      out_status_in  = out_status_ff;
      out_count_in   = out_count_ff;
      out_sum_in     = out_sum_ff;

      if (fire) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               phase_in = (b == second_sync_ff) ? PH_LEN : PH_HUNT0;
            end
            PH_LEN: begin
               bytes_left_in  = '0;
               sum_acc_in     = '0;
               held_high_in   = '0;
               held_valid_in  = 1'b0;
               rx_sum_high_in = '0;
               payload_len_in = '0;
               if (b < MIN_LENGTH) begin
                  phase_in      = PH_HUNT0;
                  emit          = 1'b1;
                  out_kind_in   = KIND_END;
                  out_byte_in   = '0;
                  out_status_in = STATUS_BADLEN;
                  out_count_in  = '0;
                  out_sum_in    = '0;
               end else begin
                  payload_len_in = b - MIN_LENGTH;
                  bytes_left_in  = b - MIN_LENGTH;
                  phase_in       = (b == MIN_LENGTH) ? PH_CKHI : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (held_valid_ff) begin
                  sum_acc_in    = sum_acc_ff + {held_high_ff, b};
                  held_valid_in = 1'b0;
                  held_high_in  = '0;
               end else begin
                  held_high_in  = b;
                  held_valid_in = 1'b1;
               end
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == 8'd1) begin
                  phase_in = PH_CKHI;
               end
               emit          = 1'b1;
               out_kind_in   = KIND_PAYLOAD;
               out_byte_in   = b;
               out_status_in = STATUS_OK;
               out_count_in  = '0;
               out_sum_in    = '0;
            end
            PH_CKHI: begin
               rx_sum_high_in = b;
               phase_in       = PH_CKLO;
            end
            PH_CKLO: begin
               phase_in       = PH_HUNT0;
               bytes_left_in  = '0;
               sum_acc_in     = '0;
               held_high_in   = '0;
               held_valid_in  = 1'b0;
               rx_sum_high_in = '0;
               payload_len_in = '0;
               emit           = 1'b1;
               out_kind_in    = KIND_END;
               out_byte_in    = '0;
               out_status_in  = (calc == rx_sum) ? STATUS_OK : STATUS_MISMATCH;
               out_count_in   = payload_len_ff;
               out_sum_in     = calc;
            end
            default: begin
               // hunting first sync, unused codes included
               phase_in = (b == first_sync_ff) ? PH_HUNT1 : PH_HUNT0;
            end
         endcase
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= FIRST_SYNC_RESET;
         second_sync_ff <= SECOND_SYNC_RESET;
         phase_ff       <= PH_HUNT0;
         bytes_left_ff  <= '0;
         sum_acc_ff     <= '0;
         held_high_ff   <= '0;
         held_valid_ff  <= 1'b0;
         rx_sum_high_ff <= '0;
         payload_len_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_FIRST_SYNC:  first_sync_ff  <= csr_wdata;
               CSR_SECOND_SYNC: second_sync_ff <= csr_wdata;
               default: ;
            endcase
         end
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         sum_acc_ff     <= sum_acc_in;
         held_high_ff   <= held_high_in;
         held_valid_ff  <= held_valid_in;
         rx_sum_high_ff <= rx_sum_high_in;
         payload_len_ff <= payload_len_in;
         out_valid_ff   <= out_valid_in;
      end
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_sum_ff    <= out_sum_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_item_kind     = out_kind_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_status    = out_status_ff;
   assign rsp_payload_count = out_count_ff;
   assign rsp_computed_sum  = out_sum_ff;

   `SPD_ASSERT(a_payload_fields_zero, (out_valid_ff && out_kind_ff == KIND_PAYLOAD) |-> (out_status_ff == STATUS_OK && out_count_ff == '0 && out_sum_ff == '0), "payload item carries end fields")
   `SPD_ASSERT(a_badlen_fields_zero, (out_valid_ff && out_status_ff == STATUS_BADLEN) |-> (out_kind_ff == KIND_END && out_count_ff == '0 && out_sum_ff == '0), "bad length end carries data")
   `SPD_ASSERT(a_held_only_in_packet, held_valid_ff |-> (phase_ff == PH_PAYLOAD || phase_ff == PH_CKHI || phase_ff == PH_CKLO), "half word held outside a packet")
   `SPD_ASSERT(a_left_within_len, bytes_left_ff <= payload_len_ff, "more bytes left than payload length")
   `SPD_ASSERT(a_cklo_ends_packet, (fire && phase_ff == PH_CKLO) |=> (out_valid_ff && out_kind_ff == KIND_END && phase_ff == PH_HUNT0), "checksum low byte gave no end item")

endmodule

// ===== sv/serial_packet_deframer.sv =====
// path: an accepted byte is registered in the input stage, and its result
//   in the result register; throughput: one byte per cycle while rsp is not
//   stalled; the result register takes a new item while the old one is taken
// reset: synchronous, active high; clears the hunt state and checksum, empties
//   both registers and loads the sync bytes with 0xFA and 0xFB
module serial_packet_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [spd_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_item_kind,
   output logic [spd_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [spd_pkg::STAT_W-1:0]    rsp_end_status,
   output logic [spd_pkg::BYTE_W-1:0]    rsp_payload_count,
   output logic [spd_pkg::SUM_W-1:0]     rsp_computed_sum,
   input  logic                          csr_write,
   input  logic [spd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spd_pkg::BYTE_W-1:0]    csr_wdata
);
   import spd_pkg::*;

   in_item_type item;
   logic        core_take;

   spd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .core_take   (core_take),
      .item        (item)
   );

   spd_core u_core (
      .clock             (clock),
      .reset             (reset),
      .item              (item),
      .core_take         (core_take),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_status    (rsp_end_status),
      .rsp_payload_count (rsp_payload_count),
      .rsp_computed_sum  (rsp_computed_sum)
   );

endmodule
